// ----- hw/rtl/mqlb_pkg.sv -----
package mqlb_pkg;

	// sizing of the queue set and the shared node pool
	localparam int NUM_QUEUES = 10;
	localparam int POOL_DEPTH = 256;
	localparam int DATA_WIDTH = 32;

	// fixed widths of the command and response fields
	localparam int QID_W = 4;
	localparam int VAL_W = 32;

	localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [PTR_W:0]    cnt_t;
	typedef logic [QIDX_W-1:0] qidx_t;

	typedef enum logic {
		MODE_APPEND = 1'b0,
		MODE_REMOVE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_DROP  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		mode_t                    mode;
		logic [QID_W-1:0]         queue_id;
		logic signed [VAL_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  out_value;
		status_t                  status;
	} rsp_t;

endpackage

// ----- hw/rtl/mqlb_ram.sv -----
module mqlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/multi_queue_linked_buffer.sv -----
// multi_queue_linked_buffer
// NUM_QUEUES fifo queues sharing one pool of POOL_DEPTH linked nodes.
// command channel: cmd (mode, queue_id, value) is taken at a rising edge
//   with start high and busy low. mode append links value behind the tail
//   of queue_id, mode remove pops the oldest value of queue_id.
// response channel: rsp (out_value, status) is shown for one cycle with
//   done high; the receiver has no way to hold it off and must take it.
//   status ok, empty (remove from empty or unknown queue, value -1) or
//   drop (append with pool exhausted or unknown queue, value 0).
// timing: busy is high in the exec state entered at the accepting edge, so a
//   new command is not taken while one is in its exec cycle. done is high
//   in the cycle right after the busy cycle and can overlap the next
//   command. in the busy cycle the registered read of the node memories
//   returns and the write-back follows.
// reset: all queues empty, free list empty, no pool entry handed out yet.
//   node memories and queue head/tail pointers need no clearing pass.
module multi_queue_linked_buffer
	(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mqlb_pkg::cmd_t cmd,
	output logic          done,
	output mqlb_pkg::rsp_t rsp
);

	import mqlb_pkg::*;

	// control
	state_t state_q, state_d;
	logic   accept;

	// command captured at the accepting edge
	cmd_t   op_s1;
	qidx_t  qidx_s1;
	logic   qok_s1;
	logic   qok;
	qidx_t  qidx;

	// per-queue bookkeeping
	logic [NUM_QUEUES-1:0] ne_q, ne_d;
	ptr_t  head_q [NUM_QUEUES];
	ptr_t  tail_q [NUM_QUEUES];
	logic  head_we, tail_we;
	ptr_t  head_d, tail_d;

	// free list and fresh-node counter
	ptr_t  free_head_q, free_head_d;
	logic  free_ne_q, free_ne_d;
	cnt_t  fresh_q, fresh_d;

	// node memories
	logic                   val_re, link_re;
	ptr_t                   val_raddr, link_raddr;
	logic [DATA_WIDTH-1:0]  val_rdata;
	ptr_t                   link_rdata;
	logic                   val_we, link_we;
	ptr_t                   val_waddr, link_waddr, link_wdata;
	logic [DATA_WIDTH-1:0]  val_wdata;

	// exec stage helpers
	ptr_t  node;
	logic  pool_empty;
	logic  signed [DATA_WIDTH-1:0] val_sx;

	// response
	rsp_t  rsp_d;
	logic  done_d;

	assign qok  = int'(cmd.queue_id) < NUM_QUEUES;
	assign qidx = QIDX_W'(cmd.queue_id);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		busy   = 1'b0;
		done_d = 1'b0;
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_EXEC: begin
				busy   = 1'b1;
				done_d = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

	assign accept = start & ~busy;

	// reads go out at the accepting edge, data is back in the exec cycle.
	// append needs the link behind the free-list head, remove needs the
	// head node of the queue (value and link)
	always_comb begin
		val_re     = accept && (cmd.mode == MODE_REMOVE);
		link_re    = accept;
		val_raddr  = (qok) ? head_q[qidx] : '0;
		link_raddr = (cmd.mode == MODE_REMOVE) ? val_raddr : free_head_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= cmd;
			qidx_s1 <= qidx;
			qok_s1  <= qok;
		end
	end

	// exec: read-modify-write of the queue, free list and node memories.
	// the next command cannot be accepted before this cycle ends, so its
	// reads always see the write-back
	assign pool_empty = !free_ne_q && (fresh_q == (PTR_W+1)'(POOL_DEPTH));
	assign node       = free_ne_q ? free_head_q : fresh_q[PTR_W-1:0];
	assign val_sx     = val_rdata;

	always_comb begin
		ne_d        = ne_q;
		head_we     = 1'b0;
		tail_we     = 1'b0;
		head_d      = node;
		tail_d      = node;
		free_head_d = free_head_q;
		free_ne_d   = free_ne_q;
		fresh_d     = fresh_q;
		val_we      = 1'b0;
		val_waddr   = node;
		val_wdata   = DATA_WIDTH'($unsigned(op_s1.value));
		link_we     = 1'b0;
		link_waddr  = node;
		link_wdata  = node;
		rsp_d       = '{out_value: '0, status: STATUS_OK};
		if (state_q == ST_EXEC) begin
			case (op_s1.mode)
				MODE_APPEND: begin
					if (!qok_s1 || pool_empty) begin
						rsp_d.status = STATUS_DROP;
					end else begin
						// take a node from the free list (self-link marks its end), else a fresh one
						if (free_ne_q) begin
							if (link_rdata == free_head_q) begin
								free_ne_d = 1'b0;
							end else begin
								free_head_d = link_rdata;
							end
						end else begin
							fresh_d = fresh_q + 1'b1;
						end
						val_we = 1'b1;
						// the new tail's own link is never read before it is
						// overwritten, so only the old tail gets linked
						if (ne_q[qidx_s1]) begin
							link_we    = 1'b1;
							link_waddr = tail_q[qidx_s1];
							link_wdata = node;
						end else begin
							head_we       = 1'b1;
							ne_d[qidx_s1] = 1'b1;
						end
						tail_we = 1'b1;
					end
				end
				MODE_REMOVE: begin
					if (!qok_s1 || !ne_q[qidx_s1]) begin
						rsp_d.out_value = '1;
						rsp_d.status    = STATUS_EMPTY;
					end else begin
						rsp_d.out_value = VAL_W'(val_sx);
						if (head_q[qidx_s1] == tail_q[qidx_s1]) begin
							ne_d[qidx_s1] = 1'b0;
						end else begin
							head_we = 1'b1;
							head_d  = link_rdata;
						end
						// push the freed node onto the free list
						link_we     = 1'b1;
						link_waddr  = head_q[qidx_s1];
						link_wdata  = free_ne_q ? free_head_q : head_q[qidx_s1];
						free_head_d = head_q[qidx_s1];
						free_ne_d   = 1'b1;
					end
				end
				default: rsp_d.status = STATUS_OK;
			endcase
		end
	end

	// control state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q        <= '0;
			free_head_q <= '0;
			free_ne_q   <= 1'b0;
			fresh_q     <= '0;
			done        <= 1'b0;
		end else begin
			ne_q        <= ne_d;
			free_head_q <= free_head_d;
			free_ne_q   <= free_ne_d;
			fresh_q     <= fresh_d;
			done        <= done_d;
		end
	end

	// queue pointers and response payload
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_q[qidx_s1] <= head_d;
		end
		if (tail_we) begin
			tail_q[qidx_s1] <= tail_d;
		end
		if (done_d) begin
			rsp <= rsp_d;
		end
	end

	// node values
	mqlb_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (POOL_DEPTH)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.re    (val_re),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	// node links, shared by the queues and the free list
	mqlb_ram #(
		.WIDTH (PTR_W),
		.DEPTH (POOL_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

endmodule

// ----- hw/rtl/mqlb_checker.sv -----
module mqlb_checker
	(
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input mqlb_pkg::rsp_t rsp
);

	import mqlb_pkg::*;

	// an accepted beat raises busy, which falls again as done rises
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (!busy && done))
		else $error("busy longer than one cycle or no response");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("response without a command");

	a_empty_val: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STATUS_EMPTY) |-> (rsp.out_value == '1))
		else $error("empty response value is not -1");

	a_drop_val: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STATUS_DROP) |-> (rsp.out_value == '0))
		else $error("dropped append value is not 0");

endmodule

bind multi_queue_linked_buffer mqlb_checker u_mqlb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
